/* rtl/core/stl_pkg.sv */
// shared types, token kind codes, lexer mode codes and character constants
// for the shell token lexer; no dependencies
package stl_pkg;

	// lexer modes
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_GT      = 3'd1;
	localparam logic [2:0] MODE_PIPE    = 3'd2;
	localparam logic [2:0] MODE_DASH    = 3'd3;
	localparam logic [2:0] MODE_COMMENT = 3'd4;
	localparam logic [2:0] MODE_STRING  = 3'd5;
	localparam logic [2:0] MODE_NAME    = 3'd6;

	// token kinds
	localparam logic [3:0] KIND_EOF         = 4'd0;
	localparam logic [3:0] KIND_READ        = 4'd1;
	localparam logic [3:0] KIND_WRITE       = 4'd2;
	localparam logic [3:0] KIND_APPEND      = 4'd3;
	localparam logic [3:0] KIND_INDENT      = 4'd4;
	localparam logic [3:0] KIND_NEWLINE     = 4'd5;
	localparam logic [3:0] KIND_PIPE        = 4'd6;
	localparam logic [3:0] KIND_PIPEVAR     = 4'd7;
	localparam logic [3:0] KIND_DASH        = 4'd8;
	localparam logic [3:0] KIND_VARIABLE    = 4'd9;
	localparam logic [3:0] KIND_NAME        = 4'd10;
	localparam logic [3:0] KIND_FUNC_SINGLE = 4'd11;
	localparam logic [3:0] KIND_FUNC_MULTI  = 4'd12;

	// source characters
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOLR  = 8'h24;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DQ    = 8'h22;

	localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
	localparam logic [23:0] LINE_ONE = 24'd1;

	// result queue
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  held;
		logic [7:0]  quote;
		logic        var_pend;
		logic [23:0] line;
	} lex_state_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic        has_char;
		logic [7:0]  char_byte;
		logic        done;
		logic [23:0] line;
		logic        unclosed;
		logic        last;
	} res_t;

endpackage

/* rtl/core/stl_step.sv */
// next-state and result logic for one source byte or end of input
// depends on stl_pkg
module stl_step import stl_pkg::*; (
	input  lex_state_t  cur,
	input  logic [7:0]  data_byte,
	input  logic        end_of_input,
	input  logic        line_start_mode,
	output lex_state_t  nxt,
	output logic [1:0]  res_cnt,
	output res_t        res0,
	output res_t        res1
);

	function automatic logic is_ws(input logic [7:0] c);
		return c inside {CH_SP, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
	endfunction

	function automatic res_t mk(input logic [3:0] kind, input logic has, input logic [7:0] ch,
			input logic done, input logic unc, input logic [23:0] ln);
		res_t r;
		r.kind      = kind;
		r.has_char  = has;
		r.char_byte = has ? ch : 8'd0;
		r.done      = done;
		r.line      = ln;
		r.unclosed  = unc;
		r.last      = 1'b0;
		return r;
	endfunction

	res_t        res [2];
	logic [1:0]  cnt;
	logic        vp;
	logic [23:0] ln;
	logic [23:0] ln_inc;
	logic        run_idle;
	logic [7:0]  c;

	assign ln_inc = (cur.line == LINE_MAX) ? cur.line : cur.line + LINE_ONE;
	assign c      = data_byte;

	always_comb begin
		nxt      = cur;
		cnt      = 2'd0;
		res[0]   = '0;
		res[1]   = '0;
		vp       = cur.var_pend;
		ln       = cur.line;
		run_idle = 1'b0;
		if (end_of_input) begin
			case (cur.mode)
				MODE_GT: begin
					res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_WRITE, 1'b0, 8'd0, 1'b1, 1'b0, ln);
					cnt = cnt + 2'd1;
				end
				MODE_PIPE: begin
					res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_PIPE, 1'b0, 8'd0, 1'b1, 1'b0, ln);
					cnt = cnt + 2'd1;
				end
				MODE_DASH: begin
					// lone dash closes as a one-byte name
					res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_NAME, 1'b1, CH_DASH, 1'b1, 1'b0, ln);
					cnt = cnt + 2'd1;
				end
				MODE_NAME: begin
					if (line_start_mode && cur.held == CH_COLON) begin
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_FUNC_SINGLE, 1'b0, 8'd0,
							1'b1, 1'b0, ln);
					end else begin
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_NAME, 1'b1, cur.held,
							1'b1, 1'b0, ln);
					end
					cnt = cnt + 2'd1;
				end
				MODE_COMMENT: begin
					ln = ln_inc;
					res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_NEWLINE, 1'b0, 8'd0, 1'b1, 1'b0, ln);
					cnt = cnt + 2'd1;
				end
				default: begin
				end
			endcase
			res[cnt[0]] = mk(KIND_EOF, 1'b0, 8'd0, 1'b1, cur.mode == MODE_STRING, ln);
			cnt = cnt + 2'd1;
			vp       = 1'b0;
			nxt.mode  = MODE_IDLE;
			nxt.held  = 8'd0;
			nxt.quote = 8'd0;
		end else begin
			case (cur.mode)
				MODE_GT: begin
					nxt.mode = MODE_IDLE;
					if (c == CH_GT) begin
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_APPEND, 1'b0, 8'd0, 1'b1, 1'b0, ln);
					end else begin
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_WRITE, 1'b0, 8'd0, 1'b1, 1'b0, ln);
						run_idle = 1'b1;
					end
					vp  = 1'b0;
					cnt = cnt + 2'd1;
				end
				MODE_PIPE: begin
					nxt.mode = MODE_IDLE;
					if (c == CH_EQ) begin
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_PIPEVAR, 1'b0, 8'd0, 1'b1, 1'b0, ln);
					end else begin
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_PIPE, 1'b0, 8'd0, 1'b1, 1'b0, ln);
						run_idle = 1'b1;
					end
					vp  = 1'b0;
					cnt = cnt + 2'd1;
				end
				MODE_DASH: begin
					if (is_ws(c) || c == CH_HASH) begin
						nxt.mode = MODE_IDLE;
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_DASH, 1'b0, 8'd0, 1'b1, 1'b0, ln);
						vp  = 1'b0;
						cnt = cnt + 2'd1;
						run_idle = 1'b1;
					end else begin
						// dash starts a name; its byte goes out now
						nxt.mode = MODE_NAME;
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_NAME, 1'b1, CH_DASH, 1'b0, 1'b0, ln);
						cnt = cnt + 2'd1;
						nxt.held = c;
					end
				end
				MODE_COMMENT: begin
					if (c == CH_NL) begin
						nxt.mode = MODE_IDLE;
						ln = ln_inc;
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_NEWLINE, 1'b0, 8'd0, 1'b1, 1'b0, ln);
						vp  = 1'b0;
						cnt = cnt + 2'd1;
					end
				end
				MODE_STRING: begin
					if (c == cur.quote) begin
						nxt.mode  = MODE_IDLE;
						nxt.quote = 8'd0;
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_NAME, 1'b0, 8'd0, 1'b1, 1'b0, ln);
						vp = 1'b0;
					end else begin
						if (c == CH_NL) begin
							ln = ln_inc;
						end
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_NAME, 1'b1, c, 1'b0, 1'b0, ln);
					end
					cnt = cnt + 2'd1;
				end
				MODE_NAME: begin
					if (is_ws(c) || c == CH_HASH) begin
						if (line_start_mode && cur.held == CH_COLON) begin
							res[cnt[0]] = mk(vp ? KIND_VARIABLE :
								((c == CH_NL) ? KIND_FUNC_MULTI : KIND_FUNC_SINGLE),
								1'b0, 8'd0, 1'b1, 1'b0, ln);
						end else begin
							res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_NAME, 1'b1, cur.held,
								1'b1, 1'b0, ln);
						end
						vp  = 1'b0;
						cnt = cnt + 2'd1;
						nxt.held = 8'd0;
						nxt.mode = MODE_IDLE;
						run_idle = 1'b1;
					end else begin
						// held byte goes out, new byte waits for a possible colon
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_NAME, 1'b1, cur.held,
							1'b0, 1'b0, ln);
						cnt = cnt + 2'd1;
						nxt.held = c;
					end
				end
				default: begin
					nxt.mode = MODE_IDLE;
					run_idle = 1'b1;
				end
			endcase

			if (run_idle) begin
				case (c)
					CH_LT: begin
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_READ, 1'b0, 8'd0, 1'b1, 1'b0, ln);
						vp  = 1'b0;
						cnt = cnt + 2'd1;
					end
					CH_GT:   nxt.mode = MODE_GT;
					CH_TAB: begin
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_INDENT, 1'b0, 8'd0, 1'b1, 1'b0, ln);
						vp  = 1'b0;
						cnt = cnt + 2'd1;
					end
					CH_HASH: nxt.mode = MODE_COMMENT;
					CH_NL: begin
						ln = ln_inc;
						res[cnt[0]] = mk(vp ? KIND_VARIABLE : KIND_NEWLINE, 1'b0, 8'd0, 1'b1, 1'b0, ln);
						vp  = 1'b0;
						cnt = cnt + 2'd1;
					end
					CH_BAR:  nxt.mode = MODE_PIPE;
					CH_DASH: nxt.mode = MODE_DASH;
					CH_DOLR: vp = 1'b1;
					CH_DQ, CH_SQ: begin
						nxt.quote = c;
						nxt.mode  = MODE_STRING;
					end
					default: begin
						if (!is_ws(c)) begin
							nxt.held = c;
							nxt.mode = MODE_NAME;
						end
					end
				endcase
			end
		end

		if (cnt == 2'd1) begin
			res[0].last = 1'b1;
		end
		if (cnt == 2'd2) begin
			res[1].last = 1'b1;
		end
		nxt.var_pend = vp;
		nxt.line     = ln;
	end

	assign res_cnt = cnt;
	assign res0    = res[0];
	assign res1    = res[1];

endmodule

/* rtl/core/stl_fifo.sv */
// small result queue: takes up to two beats per cycle, gives one
// depends on stl_pkg
module stl_fifo import stl_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     push_cnt,
	input  res_t           push0,
	input  res_t           push1,
	input  logic           pop,
	output res_t           head,
	output logic [QAW:0]   fill
);

	res_t           mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QAW:0]   fill_q;
	logic           do_pop;

	assign do_pop = pop && (fill_q != '0);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wptr_q + QAW'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			wptr_q <= wptr_q + QAW'(push_cnt);
			if (do_pop) begin
				rptr_q <= rptr_q + QAW'(1);
			end
			fill_q <= fill_q + (QAW+1)'(push_cnt) - (QAW+1)'(do_pop);
		end
	end

	assign head = mem_q[rptr_q];
	assign fill = fill_q;

endmodule

/* rtl/core/shell_token_lexer_core.sv */
// top level of the shell token lexer: state register, config register, result queue
// depends on stl_pkg, stl_step, stl_fifo
//
// lexes a shell-like language one source byte per beat and emits token beats:
// redirections, indent, newline (also for a closed comment), pipe and pipevar,
// dash, variables, names, function names and quoted string text, one text byte
// per beat; name bytes lag one input beat so a trailing colon can be dropped;
// a byte is taken every cycle while each byte yields at most one token beat and
// the token side keeps up; a byte that yields two beats (a name, a lone dash or
// a pending > or | closed by a token that emits too, or end of input behind a
// pending token) can make the byte side stall, since the token side drains
// one beat per cycle, while not stalled, out of a four-entry result queue and a
// byte is taken only while that queue holds two beats or fewer; a byte's beats
// are registered into the queue and leave from its head; no clearing pass after
// reset; line_start_mode sits at byte address 0 of the register port and should
// be written only while the lexer is idle
module shell_token_lexer_core import stl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// source bytes
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_input,
	// token beats
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [3:0]  token_kind,
	output logic        has_char,
	output logic [7:0]  char_byte,
	output logic        token_done,
	output logic [23:0] line_number,
	output logic        unclosed_string,
	output logic        last
);

	lex_state_t   st_q;
	lex_state_t   st_nxt;
	logic         lsm_q;
	logic [1:0]   res_cnt;
	res_t         res0;
	res_t         res1;
	res_t         head;
	logic [QAW:0] fill;
	logic         accept;
	logic         reg_sel;

	// register 0 decodes on the word address bit only
	assign reg_sel = (paddr[2] == 1'b0);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {31'd0, lsm_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsm_q <= 1'b1;
		end else if (psel && penable && pwrite && reg_sel) begin
			lsm_q <= pwdata[0];
		end
	end

	// room for the worst case of two beats per byte
	assign byte_stall = (fill > (QAW+1)'(QDEPTH - 2));
	assign accept     = byte_valid && !byte_stall;

	stl_step u_step (
		.cur             (st_q),
		.data_byte       (data_byte),
		.end_of_input    (end_of_input),
		.line_start_mode (lsm_q),
		.nxt             (st_nxt),
		.res_cnt         (res_cnt),
		.res0            (res0),
		.res1            (res1)
	);

	// lexer state advances only on a taken byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode     <= MODE_IDLE;
			st_q.held     <= 8'd0;
			st_q.quote    <= 8'd0;
			st_q.var_pend <= 1'b0;
			st_q.line     <= LINE_ONE;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	stl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (accept ? res_cnt : 2'd0),
		.push0    (res0),
		.push1    (res1),
		.pop      (tok_valid && !tok_stall),
		.head     (head),
		.fill     (fill)
	);

	assign tok_valid       = (fill != '0);
	assign token_kind      = head.kind;
	assign has_char        = head.has_char;
	assign char_byte       = head.char_byte;
	assign token_done      = head.done;
	assign line_number     = head.line;
	assign unclosed_string = head.unclosed;
	assign last            = head.last;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= (QAW+1)'(QDEPTH))
		else $error("result queue overfilled");

	a_line_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> st_q.line >= $past(st_q.line))
		else $error("line count went backwards");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_kind == KIND_EOF |-> last && token_done)
		else $error("eof beat not final");

	a_func_no_text: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (token_kind == KIND_FUNC_SINGLE || token_kind == KIND_FUNC_MULTI)
		|-> !has_char && token_done)
		else $error("function name beat carries text");
`endif

endmodule
